FILE: sv/blc_pkg.sv
// Shared constants, state encoding and status struct of the linear complexity core.
`default_nettype none

package blc_pkg;

    localparam int BLC_MAX_ORDER = 10;
    localparam int ORD_W         = 4;
    localparam int UORD_W        = 5;
    localparam int CPLX_W        = 11;

    localparam logic [ORD_W-1:0] ORDER_RESET = 4'd10;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FOLD,
        S_DRAIN,
        S_TAIL_RD,
        S_TAIL,
        S_PUT
    } t_seq_state;

    typedef struct packed {
        logic load_ready;
        logic publish;
    } t_seq_status;

endpackage

`default_nettype wire

FILE: sv/blc_bit_ram.sv
// One-bit-wide sequence memory with one write port and two registered read ports.
`default_nettype none

module blc_bit_ram #(
    parameter int AW = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic          i_wdata,
    input  wire logic [AW-1:0] i_raddr_a,
    input  wire logic [AW-1:0] i_raddr_b,
    output logic               o_rdata_a,
    output logic               o_rdata_b
);

    logic r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

FILE: sv/blc_fold_seq.sv
// Load counter, fold sequencer and the shared bit compare/XOR unit.
`default_nettype none

module blc_fold_seq
    import blc_pkg::*;
#(
    parameter int MAX_ORDER = BLC_MAX_ORDER
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_clear,
    input  wire logic                  i_bit_xfer,
    input  wire logic                  i_bit_value,
    input  wire logic [UORD_W-1:0]     i_used_order,
    input  wire logic                  i_out_free,
    input  wire logic                  i_rdata_a,
    input  wire logic                  i_rdata_b,
    output logic                       o_we,
    output logic [MAX_ORDER-1:0]       o_waddr,
    output logic                       o_wdata,
    output logic [MAX_ORDER-1:0]       o_raddr_a,
    output logic [MAX_ORDER-1:0]       o_raddr_b,
    output t_seq_status                o_status,
    output logic [MAX_ORDER:0]         o_sum
);

    localparam int AW = MAX_ORDER;
    localparam int CW = MAX_ORDER + 1;

    t_seq_state          r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [UORD_W-1:0]   r_n, n_n;
    logic [AW-1:0]       r_base, n_base;
    logic [AW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_half, n_half;
    logic [CW-1:0]       r_sum, n_sum;
    logic                r_diff, n_diff;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_waddr, n_waddr;

    logic [CW-1:0]       len;
    logic                last_bit;
    logic                bit_diff;

    assign len      = CW'(1) << i_used_order;
    assign last_bit = (r_cnt == (len - CW'(1)));
    assign bit_diff = i_rdata_a ^ i_rdata_b;

    // A write from a fold step in flight goes to the right half; loads use the port otherwise.
    assign o_we      = ((r_state == S_LOAD) && i_bit_xfer) || r_pend;
    assign o_waddr   = r_pend ? r_waddr : r_cnt[AW-1:0];
    assign o_wdata   = r_pend ? bit_diff : i_bit_value;
    assign o_raddr_a = r_base + r_idx;
    assign o_raddr_b = r_base + r_idx + r_half;
    assign o_sum     = r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_n     <= '0;
            r_base  <= '0;
            r_idx   <= '0;
            r_half  <= '0;
            r_sum   <= '0;
            r_diff  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
            r_base  <= n_base;
            r_idx   <= n_idx;
            r_half  <= n_half;
            r_sum   <= n_sum;
            r_diff  <= n_diff;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= n_waddr;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_n      = r_n;
        n_base   = r_base;
        n_idx    = r_idx;
        n_half   = r_half;
        n_sum    = r_sum;
        n_diff   = r_diff;
        n_pend   = (r_state == S_FOLD);
        n_waddr  = o_raddr_b;
        o_status = '{load_ready: (r_state == S_LOAD), publish: 1'b0};

        case (r_state)
            S_LOAD: begin
                if (i_clear) begin
                    n_cnt = '0;
                end else if (i_bit_xfer) begin
                    if (last_bit) begin
                        n_cnt  = '0;
                        n_sum  = '0;
                        n_base = '0;
                        n_idx  = '0;
                        n_half = AW'(len >> 1);
                        n_n    = i_used_order;
                        n_diff = 1'b0;
                        n_state = (i_used_order == '0) ? S_TAIL_RD : S_FOLD;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end
            S_FOLD: begin
                if (r_pend) begin
                    n_diff = r_diff | bit_diff;
                end
                if (r_idx == (r_half - AW'(1))) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_DRAIN: begin
                // The last pair of the pass is compared here; its XOR is written this cycle.
                if (r_diff | bit_diff) begin
                    n_base = r_base + r_half;
                    n_sum  = r_sum + CW'(r_half);
                end
                n_half  = r_half >> 1;
                n_n     = r_n - UORD_W'(1);
                n_idx   = '0;
                n_diff  = 1'b0;
                n_state = (r_n == UORD_W'(1)) ? S_TAIL_RD : S_FOLD;
            end
            S_TAIL_RD: begin
                n_state = S_TAIL;
            end
            S_TAIL: begin
                n_sum   = r_sum + CW'(i_rdata_a);
                n_state = S_PUT;
            end
            S_PUT: begin
                if (i_out_free) begin
                    o_status.publish = 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/binary_linear_complexity_core.sv
// Top level of the binary linear complexity core (Games-Chan folding).
//
//  Channel   Signals                                   Direction
//  -------   ---------------------------------------   ---------
//  bit in    i_in_valid, o_in_stall, i_bit_value        in
//  result    o_out_valid, i_out_stall, o_complexity     out
//  config    i_cfg_we, i_cfg_data (order)               in
//
// Bits are taken one per cycle while loading; a sequence holds 2^order bits.
// After the last transfer of a sequence the block stalls its input while it
// folds: each fold pass of half length h compares h bit pairs on the
// single-bit compare/XOR unit, fed by the two read ports of the bit memory,
// and then settles the pass in a drain state; tail states read the last bit
// and a put state moves the sum into the output register. If that register is
// still held by a stalled result, the block waits until it frees up.
// Reset is synchronous and active low; it clears the load count and sets the
// order to ten. The sequence memory is not cleared: a fold only reads bits
// of the current load. Writing the order drops any partial load.
`default_nettype none

module binary_linear_complexity_core
    import blc_pkg::*;
#(
    parameter int MAX_ORDER = BLC_MAX_ORDER
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_bit_value,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [CPLX_W-1:0]      o_complexity,
    input  wire logic              i_cfg_we,
    input  wire logic [ORD_W-1:0]  i_cfg_data
);

    localparam int AW = MAX_ORDER;
    localparam int CW = MAX_ORDER + 1;

    logic [ORD_W-1:0]   r_order;
    logic               r_out_valid, n_out_valid;
    logic [CPLX_W-1:0]  r_out_data;

    logic [UORD_W-1:0]  used_order;
    logic               bit_xfer;
    logic               out_free;
    t_seq_status        seq_status;
    logic [CW-1:0]      seq_sum;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic               ram_wdata;
    logic [AW-1:0]      ram_raddr_a;
    logic [AW-1:0]      ram_raddr_b;
    logic               ram_rdata_a;
    logic               ram_rdata_b;

    // Orders above the build limit are held as written but used saturated.
    assign used_order = ({1'b0, r_order} > UORD_W'(MAX_ORDER)) ?
                        UORD_W'(MAX_ORDER) : {1'b0, r_order};

    assign o_in_stall   = !seq_status.load_ready;
    assign bit_xfer     = i_in_valid && !o_in_stall;
    // The output register can take a new result when empty or draining this cycle.
    assign out_free     = !r_out_valid || !i_out_stall;
    assign o_out_valid  = r_out_valid;
    assign o_complexity = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order     <= ORDER_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_order <= i_cfg_data;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (seq_status.publish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // The complexity is reported modulo 2^11, as the result field is 11 bits.
    always_ff @(posedge i_clk) begin
        if (seq_status.publish) begin
            r_out_data <= CPLX_W'(seq_sum);
        end
    end

    blc_fold_seq #(
        .MAX_ORDER (MAX_ORDER)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (i_cfg_we),
        .i_bit_xfer   (bit_xfer),
        .i_bit_value  (i_bit_value),
        .i_used_order (used_order),
        .i_out_free   (out_free),
        .i_rdata_a    (ram_rdata_a),
        .i_rdata_b    (ram_rdata_b),
        .o_we         (ram_we),
        .o_waddr      (ram_waddr),
        .o_wdata      (ram_wdata),
        .o_raddr_a    (ram_raddr_a),
        .o_raddr_b    (ram_raddr_b),
        .o_status     (seq_status),
        .o_sum        (seq_sum)
    );

    blc_bit_ram #(
        .AW (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    // A finished sum never exceeds the sequence length.
    a_sum_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_status.publish |-> (seq_sum <= (CW'(1) << used_order)))
        else $error("complexity larger than sequence length");

    // A result is never moved into an output register that still holds a stalled one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_status.publish |-> out_free)
        else $error("result overwrote a pending output");

    // Input transfers only happen while loading, never during a fold.
    a_stall_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && !bit_xfer) |-> o_in_stall)
        else $error("input not stalled during fold write");

endmodule

`default_nettype wire

FILE: tb/sv/blc_checker.sv
// Channel monitor that predicts each sequence's linear complexity and checks the block's results.
module blc_checker
    import blc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire logic              i_bit_value,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire logic [CPLX_W-1:0] i_complexity,
    input  wire logic              i_cfg_we,
    input  wire logic [ORD_W-1:0]  i_cfg_data,
    output int                     o_pending,
    output int                     o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEQ_LEN = 1 << BLC_MAX_ORDER;

    logic [ORD_W-1:0]   order_reg = ORDER_RESET;
    logic [SEQ_LEN-1:0] seq_bits  = '0;
    int                 bit_count = 0;
    int                 mismatch_total = 0;
    logic [CPLX_W-1:0]  complexity_due[$];

    assign o_mismatches = mismatch_total;

    // Orders above the maximum are held as written but behave as the maximum.
    function automatic int active_order(input logic [ORD_W-1:0] ord);
        return (int'(ord) > BLC_MAX_ORDER) ? BLC_MAX_ORDER : int'(ord);
    endfunction

    // Games-Chan halving: fold the sequence in place, adding half the length on each
    // pass whose halves differ, and the surviving bit at the end.
    function automatic logic [CPLX_W-1:0] fold_complexity(input logic [SEQ_LEN-1:0] seq,
                                                         input int ord);
        logic [SEQ_LEN-1:0] v;
        logic               differ;
        int                 half;
        int                 sum;
        int                 n;
        int                 i;
        v   = seq;
        sum = 0;
        for (n = ord; n > 0; n--) begin
            half   = 1 << (n - 1);
            differ = 1'b0;
            for (i = 0; i < half; i++) differ |= v[i] ^ v[i + half];
            if (differ) begin
                for (i = 0; i < half; i++) v[i] = v[i] ^ v[i + half];
                sum += half;
            end
        end
        sum += int'(v[0]);
        return CPLX_W'(sum);
    endfunction

    always @(posedge i_clk) begin
        logic [CPLX_W-1:0] want;
        if (!i_rst_n) begin
            order_reg = ORDER_RESET;
            bit_count = 0;
            complexity_due.delete();
        end else begin
            // A write of the order drops whatever partial load is in progress.
            if (i_cfg_we) begin
                order_reg = i_cfg_data;
                bit_count = 0;
            end
            if (i_in_valid && !i_in_stall) begin
                seq_bits[bit_count] = i_bit_value;
                bit_count++;
                if (bit_count == (1 << active_order(order_reg))) begin
                    complexity_due = {complexity_due,
                                      fold_complexity(seq_bits, active_order(order_reg))};
                    bit_count = 0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (complexity_due.size() == 0) begin
                    $error("complexity: expected none, actual %0d", i_complexity);
                    mismatch_total++;
                end else begin
                    want = complexity_due.pop_front();
                    if (i_complexity !== want) begin
                        $error("complexity: expected %0d, actual %0d", want, i_complexity);
                        mismatch_total++;
                    end
                end
            end
        end
        o_pending = complexity_due.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
// Stimulus and verdict for the binary linear complexity core, with the checker beside it.
module tb_top
    import blc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEQ_LEN     = 1 << BLC_MAX_ORDER;
    localparam int CYCLE_LIMIT = 100000;

    // Idle patterns applied per phase. The sender gap and receiver stall rates are
    // given in percent per cycle.
    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_STALL,
        IDLE_BOTH
    } t_idle_mode;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic              i_bit_value = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [CPLX_W-1:0] o_complexity;
    logic              i_cfg_we    = 1'b0;
    logic [ORD_W-1:0]  i_cfg_data  = '0;

    t_idle_mode idle_mode = IDLE_NONE;
    int         pending_results;
    int         mismatch_count;
    int         cycle_count = 0;
    int         cur_order   = int'(ORDER_RESET);

    // Orders visited by the random phases. Small orders dominate so that most
    // transfers complete many sequences, and a few mid-size orders reach the
    // deeper fold passes.
    int phase_order[17] = '{3, 5, 0, 2, 4, 6, 1, 7, 3, 2, 4, 1, 5, 0, 3, 6, 2};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    binary_linear_complexity_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_bit_value  (i_bit_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_complexity (o_complexity),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    blc_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_bit_value  (i_bit_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_complexity (o_complexity),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending_results),
        .o_mismatches (mismatch_count)
    );

    // The result receiver draws a fresh stall decision every cycle, on the falling
    // edge, at the rate that the current idle pattern calls for.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (idle_mode == IDLE_STALL) begin
            i_out_stall <= ($urandom_range(99) < 80);
        end else if (idle_mode == IDLE_BOTH) begin
            i_out_stall <= ($urandom_range(99) < 22);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog: a hung handshake or a result that never comes ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offers one bit and holds it until the block takes it. Gaps before the offer
    // follow the idle pattern. Entered and left on a falling edge; valid is left
    // high so that back-to-back transfers never lower and raise it in one step.
    task automatic send_bit(input logic b);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 80 : (idle_mode == IDLE_BOTH) ? 22 : 0;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_bit_value <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_seq(input logic [SEQ_LEN-1:0] s, input int len);
        int i;
        for (i = 0; i < len; i++) send_bit(s[i]);
    endtask

    // Waits until every predicted result has been taken, then lets the fold of
    // the longest sequence at the current order run out. A partial load causes
    // no result, so the block counts as idle only after this pause.
    task automatic settle();
        int uo;
        uo = (cur_order > BLC_MAX_ORDER) ? BLC_MAX_ORDER : cur_order;
        i_in_valid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat ((1 << uo) + uo + 8) @(negedge i_clk);
    endtask

    task automatic write_order(input int ord);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= ORD_W'(ord);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_order  = ord;
    endtask

    // Builds one sequence of 2^uo bits, first bit at index zero. Besides plain
    // random bits, the shapes steer the fold down different paths: all zeros,
    // all ones, a lone one, sparse ones, and periodic patterns (optionally with
    // one bit flipped) whose halves stay equal for several passes.
    function automatic logic [SEQ_LEN-1:0] make_sequence(input int uo);
        logic [SEQ_LEN-1:0] s;
        int                 len;
        int                 period;
        int                 i;
        len = 1 << uo;
        s   = '0;
        case ($urandom_range(9))
            0: begin
                s = '0;
            end
            1: begin
                for (i = 0; i < len; i++) s[i] = 1'b1;
            end
            2: begin
                s[$urandom_range(len - 1)] = 1'b1;
            end
            3, 4, 5: begin
                period = 1 << $urandom_range(uo);
                for (i = 0; i < len; i++) begin
                    s[i] = (i < period) ? 1'($urandom_range(1)) : s[i - period];
                end
                if ($urandom_range(1)) s[$urandom_range(len - 1)] ^= 1'b1;
            end
            6: begin
                for (i = 0; i < len; i++) s[i] = ($urandom_range(7) == 0);
            end
            default: begin
                for (i = 0; i < len; i++) s[i] = 1'($urandom_range(1));
            end
        endcase
        return s;
    endfunction

    initial begin
        int ph;
        int uo;
        int nseq;
        int k;
        int p;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The order comes out of reset at its maximum, so a short run of bits is
        // only a partial load: no result may appear, and the next write drops it.
        for (p = 0; p < 20; p++) send_bit(1'($urandom_range(1)));

        // Order zero: each bit is a whole sequence and its own complexity.
        write_order(0);
        send_bit(1'b0);
        send_bit(1'b1);

        // Order one: all four two-bit sequences.
        write_order(1);
        for (p = 0; p < 4; p++) begin
            send_bit(p[1]);
            send_bit(p[0]);
        end

        // Order two: a late lone one, an alternating pattern and all ones. Two
        // more bits start a load that the next order write must drop.
        write_order(2);
        for (k = 0; k < 3; k++) begin
            p = (k == 0) ? 4'b0001 : (k == 1) ? 4'b1010 : 4'b1111;
            send_bit(p[3]);
            send_bit(p[2]);
            send_bit(p[1]);
            send_bit(p[0]);
        end
        send_bit(1'b1);
        send_bit(1'b0);

        // Order fifteen is used as the maximum, so a short run of bits is again
        // only a partial load that the next write drops.
        write_order(15);
        for (p = 0; p < 20; p++) send_bit(1'($urandom_range(1)));

        // Random phases. Each one writes a new order, rotates the idle pattern
        // and sometimes ends with a partial load that the next write discards.
        for (ph = 0; ph < $size(phase_order); ph++) begin
            write_order(phase_order[ph]);
            idle_mode = t_idle_mode'(ph % 4);
            uo   = (cur_order > BLC_MAX_ORDER) ? BLC_MAX_ORDER : cur_order;
            nseq = (uo <= 5) ? (12 >> uo) + 1 : 1;
            for (k = 0; k < nseq; k++) send_seq(make_sequence(uo), 1 << uo);
            if (uo > 0 && $urandom_range(1)) begin
                repeat ($urandom_range((1 << uo) - 1, 1)) send_bit(1'($urandom_range(1)));
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
